FILE: rtl/core/rse_pkg.sv
package rse_pkg;

  localparam int PARITY_SYMBOLS_DEF = 16;
  localparam int PARITY_SYMBOLS_MAX = 32;
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  typedef struct packed {
    logic step;
    logic shift;
  } rse_cell_ctrl_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ FIELD_POLY;
    end
    return acc;
  endfunction

  function automatic logic [7:0] gen_coef(input int nsym, input int idx);
    logic [7:0] g [PARITY_SYMBOLS_MAX+1];
    logic [7:0] root;
    for (int j = 0; j <= PARITY_SYMBOLS_MAX; j++) g[j] = '0;
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < PARITY_SYMBOLS_MAX; i++) begin
      if (i < nsym) begin
        for (int j = PARITY_SYMBOLS_MAX; j > 0; j--) begin
          if (j <= i + 1) g[j] = g[j-1] ^ gf_mul(g[j], root);
        end
        g[0] = gf_mul(g[0], root);
        root = gf_mul(root, 8'h02);
      end
    end
    return g[idx];
  endfunction

endpackage

FILE: rtl/core/rse_ifs.sv
interface rse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_parity;
  logic       last_of_codeword;

  modport source (output valid, output out_byte, output is_parity,
                  output last_of_codeword, input ready);
  modport sink   (input valid, input out_byte, input is_parity,
                  input last_of_codeword, output ready);
endinterface

FILE: rtl/core/rse_cell.sv
module rse_cell
  import rse_pkg::*;
#(
  parameter logic [7:0] COEF = 8'h01
) (
  input  logic           clk,
  input  logic           rst,
  input  rse_cell_ctrl_t ctrl,
  input  logic [7:0]     prev,
  input  logic [7:0]     fb,
  output logic [7:0]     q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= prev;
    end else if (ctrl.step) begin
      q <= prev ^ gf_mul(COEF, fb);
    end
  end

endmodule

FILE: rtl/core/rs_204_188_encoder_unit.sv
// Systematic Reed-Solomon encoder, GF(256) with polynomial 0x11D, generator
// roots alpha^0 .. alpha^(PARITY_SYMBOLS-1) (RS(204,188) at the default).
// Channel ingress: data_byte, end_of_message. Channel egress: out_byte,
// is_parity, last_of_codeword. valid/ready handshake on both.
// Each data item is registered in the output register and shown on egress
// in the cycle after it is taken; the parity cells update at the same edge.
// Throughput: one data item per cycle while egress is ready and no parity
// bytes drain. After the item that marks the end of a message, the
// PARITY_SYMBOLS parity bytes shift out of the cell row, top cell first, one
// per cycle while egress is ready; ingress.ready is low while they drain.
// The draining shift feeds zeros into the bottom cell, so the row is clear
// when the last parity byte leaves.
// A stall on egress holds the output register and the cell row; a new item
// is taken in the cycle the held result is taken.
// Reset (rst, synchronous) clears the cells, the drain count and the
// output valid flag.
module rs_204_188_encoder_unit
  import rse_pkg::*;
#(
  parameter int PARITY_SYMBOLS = PARITY_SYMBOLS_DEF
) (
  input logic        clk,
  input logic        rst,
  rse_in_if.sink     ingress,
  rse_out_if.source  egress
);

  localparam int CW = $clog2(PARITY_SYMBOLS + 1);

  logic [7:0]     par [PARITY_SYMBOLS];
  logic [7:0]     fb;
  logic [CW-1:0]  drain_cnt;
  logic           out_valid;
  logic           slot_free;
  logic           accept;
  logic           drain_go;
  rse_cell_ctrl_t ctrl;

  assign slot_free     = !out_valid || egress.ready;
  assign ingress.ready = (drain_cnt == '0) && slot_free;
  assign accept        = ingress.valid && ingress.ready;
  assign drain_go      = (drain_cnt != '0) && slot_free;
  assign fb            = ingress.data_byte ^ par[PARITY_SYMBOLS-1];
  assign ctrl.step     = accept;
  assign ctrl.shift    = drain_go;

  for (genvar i = 0; i < PARITY_SYMBOLS; i++) begin : g_cell
    logic [7:0] prev;
    if (i == 0) begin : g_bottom
      assign prev = '0;
    end else begin : g_upper
      assign prev = par[i-1];
    end
    rse_cell #(
      .COEF (gen_coef(PARITY_SYMBOLS, i))
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .prev (prev),
      .fb   (fb),
      .q    (par[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      drain_cnt <= '0;
    end else if (accept) begin
      out_valid <= 1'b1;
      if (ingress.end_of_message) drain_cnt <= CW'(PARITY_SYMBOLS);
    end else if (drain_go) begin
      out_valid <= 1'b1;
      drain_cnt <= drain_cnt - CW'(1);
    end else if (egress.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      egress.out_byte         <= ingress.data_byte;
      egress.is_parity        <= 1'b0;
      egress.last_of_codeword <= 1'b0;
    end else if (drain_go) begin
      egress.out_byte         <= par[PARITY_SYMBOLS-1];
      egress.is_parity        <= 1'b1;
      egress.last_of_codeword <= (drain_cnt == CW'(1));
    end
  end

  assign egress.valid = out_valid;

  logic [7:0] par_or;
  always_comb begin
    par_or = '0;
    for (int i = 0; i < PARITY_SYMBOLS; i++) par_or = par_or | par[i];
  end

  a_drain_load: assert property (@(posedge clk) disable iff (rst)
    accept && ingress.end_of_message |=> drain_cnt == CW'(PARITY_SYMBOLS))
    else $error("drain count not loaded after end of message");

  a_clear_at_last: assert property (@(posedge clk) disable iff (rst)
    egress.valid && egress.last_of_codeword |-> par_or == '0)
    else $error("parity cells not clear after last parity byte");

  a_last_is_parity: assert property (@(posedge clk) disable iff (rst)
    egress.valid && egress.last_of_codeword |-> egress.is_parity)
    else $error("last flag on a data item");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    drain_go && drain_cnt == CW'(1) |=> egress.last_of_codeword && drain_cnt == '0)
    else $error("codeword end not flagged");

endmodule
